// File: hdl/fcw_pkg.sv
// Shared constants, types and helper functions for the FAT12 cluster chain walker.
// No dependencies; every other file of the block but fcw_ram imports this package.
`default_nettype none

package fcw_pkg;

   localparam int FAT_BYTES   = 6144;
   localparam int COPY_LIMIT  = 4095;
   localparam int MAX_RESULTS = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam int INDEX_W     = 13;
   localparam int BYTE_W      = 8;
   localparam int CLUSTER_W   = 12;
   localparam int SIZE_W      = 32;
   localparam int OFFSET_W    = 32;
   localparam int COUNT_W     = 12;
   localparam int SECTOR_W    = 16;
   localparam int SPC_W       = 8;
   localparam int BPS_W       = 13;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam int BANK_DEPTH      = (FAT_BYTES + 1) / 2;
   localparam int BANK_AW         = $clog2(BANK_DEPTH);
   localparam int RESULT_W        = $clog2(MAX_RESULTS);
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int REL_SECTOR_W    = CLUSTER_W + SPC_W;
   localparam int ABS_SECTOR_W    = REL_SECTOR_W + 1;
   localparam int CLUSTER_BYTES_W = SPC_W + BPS_W;

   localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = CLUSTER_W'(2);
   localparam logic [CLUSTER_W-1:0] CHAIN_END_MIN      = 12'hFF8;
   localparam logic [COUNT_W-1:0]   COPY_LIMIT_VALUE   = COUNT_W'(COPY_LIMIT);

   localparam logic [SECTOR_W-1:0] RESET_DATA_START = SECTOR_W'(33);
   localparam logic [SPC_W-1:0]    RESET_SPC        = SPC_W'(1);
   localparam logic [BPS_W-1:0]    RESET_BPS        = BPS_W'(512);

   typedef enum logic [1:0] {
      REASON_MORE  = 2'd0,
      REASON_CHAIN = 2'd1,
      REASON_SIZE  = 2'd2,
      REASON_LIMIT = 2'd3
   } end_reason_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DATA_START      = 2'd0,
      CSR_CLUSTER_SECTORS = 2'd1,
      CSR_SECTOR_SIZE     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] data_start_sector;
      logic [SPC_W-1:0]    cluster_sectors;
      logic [BPS_W-1:0]    sector_size;
   } cfg_type;

   typedef struct packed {
      logic                 is_walk;
      logic                 write_ok;
      logic [INDEX_W-1:0]   fat_index;
      logic [BYTE_W-1:0]    fat_byte;
      logic [CLUSTER_W-1:0] start_cluster;
      logic [SIZE_W-1:0]    file_len;
   } item_type;

   typedef struct packed {
      logic                 strobe;
      logic [OFFSET_W-1:0]  byte_offset;
      logic [COUNT_W-1:0]   byte_count;
      logic [CLUSTER_W-1:0] cluster_number;
      end_reason_type       end_reason;
      logic                 last;
   } result_type;

   // chain test first, then size, then copy limit
   function automatic end_reason_type stop_reason(
      input logic [CLUSTER_W-1:0] cluster,
      input logic [COUNT_W-1:0]   done,
      input logic [SIZE_W-1:0]    size
   );
      end_reason_type reason;
      priority if (cluster < FIRST_DATA_CLUSTER || cluster >= CHAIN_END_MIN) begin
         reason = REASON_CHAIN;
      end else if (SIZE_W'(done) >= size) begin
         reason = REASON_SIZE;
      end else if (done >= COPY_LIMIT_VALUE) begin
         reason = REASON_LIMIT;
      end else begin
         reason = REASON_MORE;
      end
      return reason;
   endfunction

endpackage

`default_nettype wire

// File: hdl/fcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data <= mem_ff[read_address];
   end

endmodule

`default_nettype wire

// File: hdl/fcw_front.sv
// Front end: takes requests, tags them as table write or walk, and queues them.
// Depends on fcw_pkg.
`default_nettype none

module fcw_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_operation,
   input  wire logic [fcw_pkg::INDEX_W-1:0]    req_fat_index,
   input  wire logic [fcw_pkg::BYTE_W-1:0]     req_fat_byte,
   input  wire logic [fcw_pkg::CLUSTER_W-1:0]  req_start_cluster,
   input  wire logic [fcw_pkg::SIZE_W-1:0]     req_file_len,
   input  wire logic                           item_pop,
   output logic                                item_valid,
   output fcw_pkg::item_type                   item
);
   import fcw_pkg::*;

   item_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QCOUNT_W-1:0]  fill_ff;
   logic                 push;
   item_type             item_in;

   assign busy       = (fill_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign push       = start && !busy;
   assign item_valid = (fill_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      item_in.is_walk       = req_operation;
      // writes past the table are flagged here and dropped in the back end
      item_in.write_ok      = (req_fat_index < INDEX_W'(FAT_BYTES));
      item_in.fat_index     = req_fat_index;
      item_in.fat_byte      = req_fat_byte;
      item_in.start_cluster = req_start_cluster;
      item_in.file_len      = req_file_len;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (item_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !item_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (item_pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/fcw_back.sv
// Back end: applies table writes and walks cluster chains, one result per cluster.
// Depends on fcw_pkg and fcw_ram (two banks: even and odd table bytes).
`default_nettype none

module fcw_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fcw_pkg::cfg_type  cfg,
   input  wire logic              item_valid,
   input  wire fcw_pkg::item_type item,
   output logic                   item_pop,
   output fcw_pkg::result_type    result
);
   import fcw_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_CALC, ST_EMIT} state_type;

   state_type                   state_ff;
   logic [CLUSTER_W-1:0]        cl_ff;
   logic [SIZE_W-1:0]           size_ff;
   logic [COUNT_W-1:0]          done_ff;
   logic [RESULT_W-1:0]         count_ff;
   logic [REL_SECTOR_W-1:0]     rel_sector_ff;
   logic [CLUSTER_BYTES_W-1:0]  cluster_bytes_ff;
   logic                        odd_cluster_ff;
   logic                        off_odd_ff;
   logic                        lo_oob_ff;
   logic                        hi_oob_ff;
   logic [CLUSTER_W-1:0]        next_cl_ff;
   logic [OFFSET_W-1:0]         offset_ff;
   logic [COUNT_W-1:0]          chunk_ff;
   result_type                  result_ff;

   logic                  even_we;
   logic                  odd_we;
   logic [BANK_AW-1:0]    write_addr;
   logic [BANK_AW-1:0]    even_raddr;
   logic [BANK_AW-1:0]    odd_raddr;
   logic [BYTE_W-1:0]     even_rdata;
   logic [BYTE_W-1:0]     odd_rdata;

   logic [INDEX_W-1:0]                entry_off;
   logic [INDEX_W-1:0]                entry_half;
   logic [REL_SECTOR_W-1:0]           rel_sector_in;
   logic [CLUSTER_BYTES_W-1:0]        cluster_bytes_in;
   logic [ABS_SECTOR_W-1:0]           abs_sector_in;
   logic [ABS_SECTOR_W+BPS_W-1:0]     offset_product_in;
   logic [SIZE_W-1:0]                 remain_size_in;
   logic [COUNT_W-1:0]                remain_limit_in;
   logic [SIZE_W-1:0]                 size_clamp_in;
   logic [COUNT_W-1:0]                chunk_in;
   logic [BYTE_W-1:0]                 lo_byte_in;
   logic [BYTE_W-1:0]                 hi_byte_in;
   logic [2*BYTE_W-1:0]               word_in;
   logic [CLUSTER_W-1:0]              next_cl_in;
   end_reason_type                    empty_reason_in;
   end_reason_type                    stop_in;
   end_reason_type                    final_reason_in;

   assign result   = result_ff;
   assign item_pop = (state_ff == ST_IDLE) && item_valid;

   // table writes
   assign write_addr = BANK_AW'(item.fat_index[INDEX_W-1:1]);
   assign even_we    = item_pop && !item.is_walk && item.write_ok && !item.fat_index[0];
   assign odd_we     = item_pop && !item.is_walk && item.write_ok && item.fat_index[0];

   // entry of cl_ff sits at byte cl + cl/2; the pair straddles both banks
   assign entry_off  = INDEX_W'(cl_ff) + INDEX_W'(cl_ff[CLUSTER_W-1:1]);
   assign entry_half = entry_off >> 1;
   assign odd_raddr  = BANK_AW'(entry_half);
   assign even_raddr = BANK_AW'(entry_half + INDEX_W'(entry_off[0]));

   fcw_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_even_bank (
      .clock         (clock),
      .write_enable  (even_we),
      .write_address (write_addr),
      .write_data    (item.fat_byte),
      .read_address  (even_raddr),
      .read_data     (even_rdata)
   );

   fcw_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_odd_bank (
      .clock         (clock),
      .write_enable  (odd_we),
      .write_address (write_addr),
      .write_data    (item.fat_byte),
      .read_address  (odd_raddr),
      .read_data     (odd_rdata)
   );

   always_comb begin
      rel_sector_in    = REL_SECTOR_W'(cl_ff - FIRST_DATA_CLUSTER)
                       * REL_SECTOR_W'(cfg.cluster_sectors);
      cluster_bytes_in = CLUSTER_BYTES_W'(cfg.cluster_sectors)
                       * CLUSTER_BYTES_W'(cfg.sector_size);

      abs_sector_in     = ABS_SECTOR_W'(cfg.data_start_sector) + ABS_SECTOR_W'(rel_sector_ff);
      offset_product_in = (ABS_SECTOR_W + BPS_W)'(abs_sector_in)
                        * (ABS_SECTOR_W + BPS_W)'(cfg.sector_size);

      remain_size_in  = size_ff - SIZE_W'(done_ff);
      remain_limit_in = COPY_LIMIT_VALUE - done_ff;
      size_clamp_in   = (SIZE_W'(cluster_bytes_ff) > remain_size_in) ?
                        remain_size_in : SIZE_W'(cluster_bytes_ff);
      chunk_in        = (size_clamp_in > SIZE_W'(remain_limit_in)) ?
                        remain_limit_in : size_clamp_in[COUNT_W-1:0];

      lo_byte_in = lo_oob_ff ? '0 : (off_odd_ff ? odd_rdata : even_rdata);
      hi_byte_in = hi_oob_ff ? '0 : (off_odd_ff ? even_rdata : odd_rdata);
      word_in    = {hi_byte_in, lo_byte_in};
      next_cl_in = odd_cluster_ff ? word_in[2*BYTE_W-1:4] : word_in[CLUSTER_W-1:0];

      empty_reason_in = stop_reason(item.start_cluster, '0, item.file_len);
      stop_in         = stop_reason(next_cl_ff, done_ff, size_ff);
      // result cap: an eighth result always closes the walk
      final_reason_in = (stop_in == REASON_MORE && count_ff == RESULT_W'(MAX_RESULTS - 1)) ?
                        REASON_LIMIT : stop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         result_ff.strobe <= 1'b0;
         cl_ff            <= '0;
         done_ff          <= '0;
         count_ff         <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               result_ff.strobe <= item_valid && item.is_walk
                                   && (empty_reason_in != REASON_MORE);
               if (item_valid && item.is_walk) begin
                  cl_ff    <= item.start_cluster;
                  size_ff  <= item.file_len;
                  done_ff  <= '0;
                  count_ff <= '0;
                  if (empty_reason_in != REASON_MORE) begin
                     result_ff.byte_offset    <= '0;
                     result_ff.byte_count     <= '0;
                     result_ff.cluster_number <= item.start_cluster;
                     result_ff.end_reason     <= empty_reason_in;
                     result_ff.last           <= 1'b1;
                  end else begin
                     state_ff <= ST_LOOK;
                  end
               end
            end
            ST_LOOK: begin
               result_ff.strobe <= 1'b0;
               rel_sector_ff    <= rel_sector_in;
               cluster_bytes_ff <= cluster_bytes_in;
               odd_cluster_ff   <= cl_ff[0];
               off_odd_ff       <= entry_off[0];
               lo_oob_ff        <= ((INDEX_W + 1)'(entry_off) >= (INDEX_W + 1)'(FAT_BYTES));
               hi_oob_ff        <= ((INDEX_W + 1)'(entry_off) >= (INDEX_W + 1)'(FAT_BYTES - 1));
               state_ff         <= ST_CALC;
            end
            ST_CALC: begin
               result_ff.strobe <= 1'b0;
               offset_ff        <= offset_product_in[OFFSET_W-1:0];
               chunk_ff         <= chunk_in;
               done_ff          <= done_ff + chunk_in;
               next_cl_ff       <= next_cl_in;
               state_ff         <= ST_EMIT;
            end
            ST_EMIT: begin
               result_ff.strobe         <= 1'b1;
               result_ff.byte_offset    <= offset_ff;
               result_ff.byte_count     <= chunk_ff;
               result_ff.cluster_number <= cl_ff;
               result_ff.end_reason     <= final_reason_in;
               result_ff.last           <= (final_reason_in != REASON_MORE);
               count_ff                 <= count_ff + 1'b1;
               cl_ff                    <= next_cl_ff;
               state_ff <= (final_reason_in != REASON_MORE) ? ST_IDLE : ST_LOOK;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hdl/fat12_cluster_chain_walker_top.sv
// Top level of the FAT12 cluster chain walker: config registers, front queue, back walker.
// Depends on fcw_pkg, fcw_front and fcw_back (which holds the fcw_ram banks).
//
// Usage:
//  - Requests: a request is taken at a rising edge with start high and busy low.
//    req_operation 0 writes req_fat_byte at table byte req_fat_index (indexes past
//    the table are dropped); 1 walks the chain from req_start_cluster for
//    req_file_len bytes. Load every table byte a walk touches before walking.
//  - Requests land in a two-entry queue; busy is high only while it is full.
//  - A table write retires as the back end pops it. A walk has a dispatch
//    step, then per cluster a table lookup and sector multiply step, an offset
//    multiply with clamp and next-entry decode step and a result step, for at
//    most eight clusters.
//  - With an idle block a walk's request is queued, then dispatched; each result
//    then passes the lookup, calc and result states, and an empty walk answers
//    straight from dispatch with a registered result.
//  - Results: rsp_strobe is high for exactly one cycle per result; the receiver
//    cannot stall, so every result must be captured on its strobe. rsp_last
//    closes a walk, with rsp_end_reason telling why.
//  - Config: csr_write_enable writes csr_write_data into register csr_index
//    (data start sector, sectors per cluster, bytes per sector); write only
//    when the block is idle. Index 3 is ignored.
//  - Reset (synchronous): empties the queue, idles the walker, restores config
//    defaults (33, 1, 512). Table contents are kept and are not defined after
//    power-up.
`default_nettype none

module fat12_cluster_chain_walker_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_operation,
   input  wire logic [fcw_pkg::INDEX_W-1:0]       req_fat_index,
   input  wire logic [fcw_pkg::BYTE_W-1:0]        req_fat_byte,
   input  wire logic [fcw_pkg::CLUSTER_W-1:0]     req_start_cluster,
   input  wire logic [fcw_pkg::SIZE_W-1:0]        req_file_len,
   output logic                                   rsp_strobe,
   output logic      [fcw_pkg::OFFSET_W-1:0]      rsp_byte_offset,
   output logic      [fcw_pkg::COUNT_W-1:0]       rsp_byte_count,
   output logic      [fcw_pkg::CLUSTER_W-1:0]     rsp_cluster_number,
   output logic      [1:0]                        rsp_end_reason,
   output logic                                   rsp_last,
   input  wire logic                              csr_write_enable,
   input  wire logic [fcw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [fcw_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import fcw_pkg::*;

   cfg_type    cfg_ff;
   logic       item_valid;
   logic       item_pop;
   item_type   item;
   result_type result;

   // config registers, plain write port
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_start_sector <= RESET_DATA_START;
         cfg_ff.cluster_sectors   <= RESET_SPC;
         cfg_ff.sector_size       <= RESET_BPS;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DATA_START:
               cfg_ff.data_start_sector <= csr_write_data[SECTOR_W-1:0];
            CSR_CLUSTER_SECTORS:
               cfg_ff.cluster_sectors <= csr_write_data[SPC_W-1:0];
            CSR_SECTOR_SIZE:
               cfg_ff.sector_size <= csr_write_data[BPS_W-1:0];
            default: ;
         endcase
      end
   end

   // front: take and classify requests
   fcw_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_fat_index     (req_fat_index),
      .req_fat_byte      (req_fat_byte),
      .req_start_cluster (req_start_cluster),
      .req_file_len      (req_file_len),
      .item_pop          (item_pop),
      .item_valid        (item_valid),
      .item              (item)
   );

   // back: table writes and chain walks
   fcw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .result     (result)
   );

   assign rsp_strobe         = result.strobe;
   assign rsp_byte_offset    = result.byte_offset;
   assign rsp_byte_count     = result.byte_count;
   assign rsp_cluster_number = result.cluster_number;
   assign rsp_end_reason     = result.end_reason;
   assign rsp_last           = result.last;

endmodule

`default_nettype wire

// File: hdl/fcw_checker.sv
// Port-level checks for the FAT12 cluster chain walker, bound to the top level.
// Depends on fcw_pkg and fat12_cluster_chain_walker_top.
`default_nettype none

module fcw_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic [1:0] rsp_end_reason,
   input wire logic       rsp_last
);
   import fcw_pkg::*;

   // reset drops any pending result and empties the queue
   assert property (@(posedge clock) reset |=> !rsp_strobe && !busy)
      else $error("result or busy right after reset");

   // a closing result always carries a stop reason
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> rsp_end_reason != REASON_MORE)
      else $error("last result without a stop reason");

   // a non-closing result says more follow
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> rsp_end_reason == REASON_MORE)
      else $error("stop reason on a non-last result");

   // results of one walk are kept apart by the lookup and calc states
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> !rsp_strobe ##1 !rsp_strobe)
      else $error("results of a walk too close together");

endmodule

bind fat12_cluster_chain_walker_top fcw_checker u_fcw_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_end_reason (rsp_end_reason),
   .rsp_last       (rsp_last)
);

`default_nettype wire
